>>> src/xed_pkg.sv
`timescale 1ns / 1ps
// xed_pkg: shared types, entity table and match function for the XML entity decoder.
// Used by xed_ctrl, xed_datapath and xml_entity_decoder_core.
package xed_pkg;

	localparam int EntCount  = 5;
	localparam int EntMaxLen = 6;
	localparam int HoldDepth = 6;	// up to five held bytes plus the breaking byte
	localparam int CntW      = 3;

	localparam logic [7:0] ChAmp = 8'h26;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       string_end;
	} out_item_t;

	typedef logic [HoldDepth-1:0][7:0] hold_t;

	typedef struct packed {
		logic accept;
		logic emit_next;
	} dp_cmd_t;

	typedef struct packed {
		logic multi;		// incoming item yields more than one result
		logic done;			// byte being emitted is the last of the run
		logic out_free;		// output register can take a byte this cycle
	} dp_sts_t;

	typedef struct packed {
		logic       full;
		logic       prefix;
		logic [7:0] code;
	} match_t;

	localparam logic [EntCount-1:0][EntMaxLen-1:0][7:0] EntText = '{
		'{8'h3b, 8'h73, 8'h6f, 8'h70, 8'h61, 8'h26},	// &apos;
		'{8'h3b, 8'h74, 8'h6f, 8'h75, 8'h71, 8'h26},	// &quot;
		'{8'h00, 8'h00, 8'h3b, 8'h74, 8'h67, 8'h26},	// &gt;
		'{8'h00, 8'h00, 8'h3b, 8'h74, 8'h6c, 8'h26},	// &lt;
		'{8'h00, 8'h3b, 8'h70, 8'h6d, 8'h61, 8'h26}		// &amp;
	};

	localparam logic [EntCount-1:0][CntW-1:0] EntLen = '{
		3'd6, 3'd6, 3'd4, 3'd4, 3'd5
	};

	localparam logic [EntCount-1:0][7:0] EntCode = '{
		8'h27, 8'h22, 8'h3e, 8'h3c, 8'h26
	};

	// Compare held prefix plus the new byte against every entity.
	function automatic match_t ent_match(hold_t held, logic [CntW-1:0] n, logic [7:0] b);
		match_t m;
		logic   ok;
		m = '0;
		for (int e = 0; e < EntCount; e++) begin
			ok = ({1'b0, EntLen[e]} >= ({1'b0, n} + 4'd1));
			for (int i = 0; i < EntMaxLen; i++) begin
				if (CntW'(i) < n && EntText[e][i] != held[i])
					ok = 1'b0;
				if (CntW'(i) == n && EntText[e][i] != b)
					ok = 1'b0;
			end
			if (ok) begin
				if ({1'b0, EntLen[e]} == ({1'b0, n} + 4'd1)) begin
					m.full = 1'b1;
					m.code = EntCode[e];
				end else begin
					m.prefix = 1'b1;
				end
			end
		end
		return m;
	endfunction

endpackage

>>> src/xed_ctrl.sv
`timescale 1ns / 1ps
// xed_ctrl: controller for the XML entity decoder; accepts items and sequences flushes.
// Depends on xed_pkg.
module xed_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  xed_pkg::dp_sts_t sts,
	output xed_pkg::dp_cmd_t cmd
);
	import xed_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt     = state_q;
		in_ready      = 1'b0;
		cmd.accept    = 1'b0;
		cmd.emit_next = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = sts.out_free;
				cmd.accept = in_valid && sts.out_free;
				if (cmd.accept && sts.multi)
					state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit_next = sts.out_free;
				if (cmd.emit_next && sts.done)
					state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> src/xed_datapath.sv
`timescale 1ns / 1ps
// xed_datapath: hold buffer, entity match, run counters and output register.
// Depends on xed_pkg.
module xed_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  xed_pkg::in_item_t in_data,
	input  xed_pkg::dp_cmd_t  cmd,
	output xed_pkg::dp_sts_t  sts,
	output logic              out_valid,
	input  logic              out_ready,
	output xed_pkg::out_item_t out_data
);
	import xed_pkg::*;

	hold_t           buf_q;
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] idx_q;
	logic [CntW-1:0] emit_q;
	logic            last_q;
	logic            out_valid_q;
	out_item_t       out_q;

	match_t          m;
	logic            is_amp;
	logic            extend;
	logic [CntW-1:0] e_cnt;
	logic [CntW-1:0] n_cnt;
	logic [7:0]      first_byte;
	logic            load_first;

	always_comb begin
		m      = ent_match(buf_q, cnt_q, in_data.in_byte);
		is_amp = (in_data.in_byte == ChAmp);
		extend = m.prefix && (cnt_q < CntW'(HoldDepth - 1));
		if (m.full) begin
			e_cnt = CntW'(1);
			n_cnt = '0;
		end else if (extend) begin
			e_cnt = in_data.in_last ? cnt_q + CntW'(1) : '0;
			n_cnt = in_data.in_last ? '0 : cnt_q + CntW'(1);
		end else begin
			// broken match: held bytes go out, a '&' restarts the hold
			e_cnt = cnt_q + CntW'((!is_amp || in_data.in_last) ? 1 : 0);
			n_cnt = CntW'((is_amp && !in_data.in_last) ? 1 : 0);
		end
		if (m.full)
			first_byte = m.code;
		else if (cnt_q == '0)
			first_byte = in_data.in_byte;
		else
			first_byte = buf_q[0];
	end

	assign load_first   = cmd.accept && (e_cnt != '0);
	assign sts.multi    = (e_cnt > CntW'(1));
	assign sts.done     = (idx_q == emit_q - CntW'(1));
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				cnt_q <= n_cnt;
				idx_q <= CntW'(1);
			end else if (cmd.emit_next) begin
				idx_q <= idx_q + CntW'(1);
			end
			if (load_first || cmd.emit_next)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			emit_q <= e_cnt;
			last_q <= in_data.in_last;
			if (!m.full)
				buf_q[cnt_q] <= in_data.in_byte;
		end
		if (load_first) begin
			out_q.out_byte   <= first_byte;
			out_q.run_end    <= (e_cnt == CntW'(1));
			out_q.string_end <= (e_cnt == CntW'(1)) && in_data.in_last;
		end else if (cmd.emit_next) begin
			out_q.out_byte   <= buf_q[idx_q];
			out_q.run_end    <= sts.done;
			out_q.string_end <= sts.done && last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> src/xml_entity_decoder_core.sv
`timescale 1ns / 1ps
// xml_entity_decoder_core: streaming unescape of the five predefined XML entities.
// Depends on xed_pkg, xed_ctrl and xed_datapath.
//
//   channel | direction | handshake           | payload
//   in      | sink      | in_valid / in_ready | in_data  (in_item_t: in_byte, in_last)
//   out     | source    | out_valid/out_ready | out_data (out_item_t: out_byte, run_end,
//           |           |                     |           string_end)
//
// An item with zero or one result leaves the controller idle; its result is
// registered and shows the cycle after the transfer. An item with k results (k up
// to 6, a flush of held bytes) goes out one byte per cycle from the hold buffer
// while the output is free, with in_ready low after the first. Output stalls hold
// the output register and drop in_ready. Reset clears hold count and output valid.
module xml_entity_decoder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  xed_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output xed_pkg::out_item_t out_data
);
	import xed_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	xed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	xed_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	// a string's final input always produces a result
	a_last_yields: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.in_last |=> out_valid)
		else $error("last input produced no output");

	// a multi-byte flush blocks the input side
	a_flush_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && sts.multi |=> !in_ready)
		else $error("input taken during flush");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.emit_next))
		else $error("accept and emit issued together");

	// string_end only closes a run
	a_str_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.string_end |-> out_data.run_end)
		else $error("string_end without run_end");
`endif

endmodule
